// ----- hdl/ablp_pkg.sv -----
// Package for the binomial lattice pricer: payload types, status codes, FSM states.
// No dependencies.
`timescale 1ns / 1ps
package ablp_pkg;

    typedef struct packed {
        logic        option_put;
        logic [31:0] spot;
        logic [31:0] strike;
        logic [10:0] steps;
        logic [31:0] up_factor;
        logic [31:0] down_factor;
        logic [31:0] up_prob;
        logic [31:0] discount;
    } ablp_in_t;

    typedef struct packed {
        logic [31:0] price;
        logic [1:0]  status;
    } ablp_out_t;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_ZERO_STEP = 2'd1;
    localparam logic [1:0] STATUS_BAD_PROB  = 2'd2;

    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DOWN,     // spot times d, n times
        ST_LEAF,     // leaf spot times u, twice per leaf
        ST_RD,       // issue node reads
        ST_WAIT,     // read data lands
        ST_MUL,      // multiply stage
        ST_MUL2,     // discount / payoff stage
        ST_WR,       // write node back
        ST_DONE
    } ablp_state_t;

    // Controller commands to the datapath
    typedef struct packed {
        logic load;
        logic down_mul;
        logic leaf_mul;      // x = x*u
        logic leaf_wr;       // write x and payoff at addr
        logic node_rd;       // read value[i], value[i+1], spot[i+1]
        logic node_mul;
        logic node_mul2;
        logic node_wr;
        logic root_rd;
    } ablp_cmd_t;

    // Product (v*f)>>30, saturated to 32 bits
    function automatic logic [31:0] mul_sat(input logic [63:0] prod);
        logic [33:0] hi;
        begin
            hi = prod[63:30];
            mul_sat = (hi[33:32] != 2'b00) ? 32'hFFFF_FFFF : hi[31:0];
        end
    endfunction

    function automatic logic [31:0] payoff(input logic put, input logic [31:0] s,
                                           input logic [31:0] k);
        begin
            if (put) payoff = (k > s) ? k - s : 32'd0;
            else     payoff = (s > k) ? s - k : 32'd0;
        end
    endfunction

endpackage

// ----- hdl/ablp_datapath.sv -----
// Datapath of the lattice pricer: node memories, multipliers, payoff and max.
// Depends on ablp_pkg.
`timescale 1ns / 1ps
module ablp_datapath #(
    parameter int MAX_STEPS = 1024,
    parameter int AW        = 10
) (
    input  logic              aclk,
    input  ablp_pkg::ablp_cmd_t cmd,
    input  ablp_pkg::ablp_in_t  req,
    input  logic [AW:0]       addr,
    output logic [31:0]       root_value
);
    import ablp_pkg::*;

    logic [31:0] value_mem [0:MAX_STEPS];
    logic [31:0] spot_mem  [0:MAX_STEPS];

    logic [31:0] x_reg;
    logic [31:0] v0_reg, v1_reg, s1_reg;
    logic [31:0] w_reg, s_reg;
    logic [31:0] cont_reg, ex_reg;
    logic [31:0] rv_reg;
    logic [31:0] x_next, wr_value, wr_spot;
    logic [63:0] prod_x;
    logic [63:0] acc;
    logic [31:0] qprob;
    logic [AW:0] addr1;

    assign addr1  = addr + 1'b1;
    assign qprob  = ONE_Q30 - req.up_prob;
    assign prod_x = {32'd0, x_reg} * {32'd0, (cmd.down_mul ? req.down_factor : req.up_factor)};

    // Chain multiply for leaf spots
    always_comb begin
        x_next = x_reg;
        if (cmd.load) x_next = req.spot;
        else if (cmd.down_mul || cmd.leaf_mul) x_next = mul_sat(prod_x);
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
    end

    // Memory read port: registered data
    always_ff @(posedge aclk) begin
        if (cmd.node_rd) begin
            v0_reg <= value_mem[addr];
            v1_reg <= value_mem[addr1];
            s1_reg <= spot_mem[addr1];
        end
        if (cmd.root_rd) rv_reg <= value_mem[addr];
    end
    assign root_value = rv_reg;

    // Weighted sum and node spot
    assign acc = {32'd0, req.up_prob} * {32'd0, v0_reg} + {32'd0, qprob} * {32'd0, v1_reg};
    always_ff @(posedge aclk) begin
        if (cmd.node_mul) begin
            w_reg <= acc[61:30];
            s_reg <= mul_sat({32'd0, s1_reg} * {32'd0, req.up_factor});
        end
        if (cmd.node_mul2) begin
            cont_reg <= mul_sat({32'd0, w_reg} * {32'd0, req.discount});
            ex_reg   <= payoff(req.option_put, s_reg, req.strike);
        end
    end

    // Write back: leaf or interior node
    always_comb begin
        if (cmd.leaf_wr) begin
            wr_spot  = x_reg;
            wr_value = payoff(req.option_put, x_reg, req.strike);
        end else begin
            wr_spot  = s_reg;
            wr_value = (cont_reg > ex_reg) ? cont_reg : ex_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.leaf_wr || cmd.node_wr) begin
            value_mem[addr] <= wr_value;
            spot_mem[addr]  <= wr_spot;
        end
    end

endmodule

// ----- hdl/ablp_ctrl.sv -----
// Controller of the lattice pricer: sequences leaf fill and backward induction.
// Depends on ablp_pkg.
`timescale 1ns / 1ps
module ablp_ctrl #(
    parameter int MAX_STEPS = 1024,
    parameter int AW        = 10
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ablp_pkg::ablp_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ablp_pkg::ablp_out_t m_data,
    output ablp_pkg::ablp_cmd_t cmd,
    output ablp_pkg::ablp_in_t  req,
    output logic [AW:0]         addr,
    input  logic [31:0]         root_value
);
    import ablp_pkg::*;

    localparam logic [AW:0] MAX_N = (AW + 1)'(MAX_STEPS);

    ablp_state_t state_reg, state_next;
    ablp_in_t    req_reg;
    logic [AW:0] n_reg, n_next;
    logic [AW:0] cnt_reg, cnt_next;     // down count, leaf index or node index
    logic [AW:0] step_reg, step_next;   // interior step t-1
    logic        half_reg, half_next;   // second u multiply of a leaf
    logic        busy_reg, busy_next;   // result pending
    ablp_out_t   out_reg, out_next;
    logic        mv_reg, mv_next;
    logic        accept;
    logic [AW:0] n_in;

    assign s_ready = (state_reg == ST_IDLE) && !mv_reg;
    assign accept  = s_valid && s_ready;
    assign m_valid = mv_reg;
    assign m_data  = out_reg;
    // Pass the incoming transaction through while it is accepted so the spot loads with it
    assign req     = accept ? s_data : req_reg;

    always_comb begin
        if (32'(s_data.steps) > MAX_STEPS) n_in = MAX_N;
        else n_in = (AW + 1)'(s_data.steps);
    end

    // Next state and counters
    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        cnt_next   = cnt_reg;
        step_next  = step_reg;
        half_next  = half_reg;
        busy_next  = busy_reg;
        out_next   = out_reg;
        mv_next    = mv_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    n_next   = n_in;
                    cnt_next = '0;
                    if (s_data.steps == 11'd0) begin
                        out_next = '{price: 32'd0, status: STATUS_ZERO_STEP};
                        mv_next  = 1'b1;
                    end else if (s_data.up_prob > ONE_Q30) begin
                        out_next = '{price: 32'd0, status: STATUS_BAD_PROB};
                        mv_next  = 1'b1;
                    end else begin
                        state_next = ST_DOWN;
                    end
                end
            end
            ST_DOWN: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg + 1'b1 == n_reg) begin
                    state_next = ST_LEAF;
                    cnt_next   = n_reg;
                    half_next  = 1'b0;
                end
            end
            ST_LEAF: begin
                // at half 0: write leaf cnt, then two multiplies
                if (!half_reg) begin
                    if (cnt_reg == '0) begin
                        state_next = ST_RD;
                        step_next  = n_reg - 1'b1;
                        cnt_next   = '0;
                    end else begin
                        half_next = 1'b1;
                    end
                end else begin
                    half_next = 1'b0;
                    cnt_next  = cnt_reg - 1'b1;
                end
            end
            ST_RD:   state_next = ST_WAIT;
            ST_WAIT: state_next = ST_MUL;
            ST_MUL:  state_next = ST_MUL2;
            ST_MUL2: state_next = ST_WR;
            ST_WR: begin
                if (cnt_reg == step_reg) begin
                    cnt_next = '0;
                    if (step_reg == '0) state_next = ST_DONE;
                    else begin
                        step_next  = step_reg - 1'b1;
                        state_next = ST_RD;
                    end
                end else begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_DONE: begin
                if (busy_reg) begin
                    out_next   = '{price: root_value, status: STATUS_OK};
                    mv_next    = 1'b1;
                    busy_next  = 1'b0;
                    state_next = ST_IDLE;
                end else begin
                    busy_next = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        cmd  = '0;
        addr = cnt_reg;
        case (state_reg)
            ST_IDLE: cmd.load = 1'b1;
            ST_DOWN: cmd.down_mul = 1'b1;
            ST_LEAF: begin
                cmd.leaf_wr  = !half_reg;
                cmd.leaf_mul = cnt_reg != '0 || half_reg;
            end
            ST_RD:   cmd.node_rd = 1'b1;
            ST_MUL:  cmd.node_mul = 1'b1;
            ST_MUL2: cmd.node_mul2 = 1'b1;
            ST_WR:   cmd.node_wr = 1'b1;
            ST_DONE: begin
                cmd.root_rd = 1'b1;
                addr        = '0;
            end
            default: cmd = '0;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg    <= 1'b0;
            busy_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
            busy_reg  <= busy_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) req_reg <= s_data;
        n_reg    <= n_next;
        cnt_reg  <= cnt_next;
        step_reg <= step_next;
        half_reg <= half_next;
        out_reg  <= out_next;
    end

endmodule

// ----- hdl/american_binomial_lattice_pricer.sv -----
// American option pricer on a binomial lattice, one request at a time.
// Each request runs the down chain, the leaf fill, then backward induction through the node
// memory (read, wait, multiply, discount/payoff, write per node), then a root read.
// A new request is accepted only once the last result has been taken; errors answer in
// the cycle after accept.
// Reset (aresetn, synchronous) idles the controller; node memories are not cleared.
`timescale 1ns / 1ps
module american_binomial_lattice_pricer #(
    parameter int MAX_STEPS = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ablp_pkg::ablp_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ablp_pkg::ablp_out_t m_data
);
    import ablp_pkg::*;

    localparam int AW = $clog2(MAX_STEPS);

    ablp_cmd_t   cmd;
    ablp_in_t    req;
    logic [AW:0] addr;
    logic [31:0] root_value;

    ablp_ctrl #(.MAX_STEPS(MAX_STEPS), .AW(AW)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cmd(cmd), .req(req), .addr(addr), .root_value(root_value)
    );

    ablp_datapath #(.MAX_STEPS(MAX_STEPS), .AW(AW)) u_dp (
        .aclk(aclk), .cmd(cmd), .req(req), .addr(addr), .root_value(root_value)
    );

endmodule
